// ----- rtl/ccd_pkg.sv -----
// ccd_pkg: shared types, constants and lookup functions for the core count
// hotplug decision block. No dependencies; every rtl module imports it.
package ccd_pkg;

	// Fraction bits of the average run-queue length
	localparam int LOAD_FRAC_BITS = 11;

	// Field widths
	localparam int NOW_W    = 32;
	localparam int AVG_W    = 20;
	localparam int RUN_W    = 10;
	localparam int CORES_W  = 3;
	localparam int DEC_W    = 2;
	localparam int DIV_W    = 8;
	localparam int QUIET_W  = 16;
	localparam int DWELL_W  = 32;
	localparam int DLIM_W   = 8;

	// Stream payload widths, padded to whole bytes
	localparam int IN_BITS  = NOW_W + AVG_W + RUN_W + CORES_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = DEC_W + CORES_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORES    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_SAVING = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_HYST_DIV     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_QUIET_MS     = CFG_IDX_W'(3);

	// Ladder thresholds and shifts
	localparam int THR_BASE_W   = 5;
	localparam int HYST_W       = 4;
	localparam int SHIFT_NORMAL = 3;
	localparam int SHIFT_SAVING = 1;
	localparam int LADDER_STEPS = 3;
	localparam int THR_W        = THR_BASE_W + LOAD_FRAC_BITS - SHIFT_SAVING;
	localparam int CMP_W        = (THR_W > AVG_W) ? THR_W : AVG_W;
	localparam logic [THR_BASE_W-1:0] LADDER_NORMAL [LADDER_STEPS] = '{
		THR_BASE_W'(7), THR_BASE_W'(9), THR_BASE_W'(10)
	};
	localparam logic [THR_BASE_W-1:0] LADDER_SAVING = THR_BASE_W'(5);

	localparam logic [CORES_W-1:0] CORES_MAX = CORES_W'(4);

	typedef enum logic [DEC_W-1:0] {
		DEC_IDLE = 2'd0,
		DEC_DOWN = 2'd1,
		DEC_UP   = 2'd2
	} decision_t;

	typedef struct packed {
		logic [CORES_W-1:0] max_cores;
		logic               power_saving;
		logic [DIV_W-1:0]   hyst_div;
		logic [QUIET_W-1:0] quiet_ms;
	} cfg_t;

	// Hysteresis addition: ladder step (8 normal, 2 saving) over the divisor
	function automatic logic [HYST_W-1:0] hyst_amount(input logic ps,
			input logic [DIV_W-1:0] div);
		logic [HYST_W-1:0] h;
		h = '0;
		if (ps) begin
			priority if (div == DIV_W'(1)) h = HYST_W'(2);
			else if (div == DIV_W'(2))     h = HYST_W'(1);
			else                           h = '0;
		end else begin
			priority if (div == DIV_W'(0)) h = '0;
			else if (div == DIV_W'(1))     h = HYST_W'(8);
			else if (div == DIV_W'(2))     h = HYST_W'(4);
			else if (div <= DIV_W'(4))     h = HYST_W'(2);
			else if (div <= DIV_W'(8))     h = HYST_W'(1);
			else                           h = '0;
		end
		return h;
	endfunction

	// Runnable count needed to go up from n cores
	function automatic logic [RUN_W-1:0] up_count(input logic [CORES_W-1:0] n);
		logic [RUN_W-1:0] v;
		unique case (n)
			3'd1:    v = RUN_W'(12);
			3'd2:    v = RUN_W'(20);
			3'd3:    v = RUN_W'(25);
			default: v = '0;
		endcase
		return v;
	endfunction

	// Runnable count at or below which n cores may go down
	function automatic logic [RUN_W-1:0] down_count(input logic [CORES_W-1:0] n);
		logic [RUN_W-1:0] v;
		unique case (n)
			3'd2:    v = RUN_W'(7);
			3'd3:    v = RUN_W'(10);
			3'd4:    v = RUN_W'(18);
			default: v = '0;
		endcase
		return v;
	endfunction

	// Dwell needed before going up from n cores
	function automatic logic [DLIM_W-1:0] up_dwell(input logic [CORES_W-1:0] n);
		logic [DLIM_W-1:0] v;
		unique case (n)
			3'd1, 3'd2, 3'd3: v = DLIM_W'(140);
			default:          v = '0;
		endcase
		return v;
	endfunction

	// Dwell needed before going down from n cores
	function automatic logic [DLIM_W-1:0] down_dwell(input logic [CORES_W-1:0] n);
		logic [DLIM_W-1:0] v;
		unique case (n)
			3'd2, 3'd3, 3'd4: v = DLIM_W'(190);
			default:          v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/ccd_cfg_regs.sv -----
// ccd_cfg_regs: configuration register file written through the cfg channel.
// Depends on ccd_pkg.
module ccd_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ccd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ccd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output ccd_pkg::cfg_t                   cfg
);
	import ccd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_cores    <= CORES_MAX;
			cfg_q.power_saving <= 1'b0;
			cfg_q.hyst_div     <= DIV_W'(2);
			cfg_q.quiet_ms     <= QUIET_W'(100);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_CORES:    cfg_q.max_cores    <= cfg_data[CORES_W-1:0];
				CFG_POWER_SAVING: cfg_q.power_saving <= cfg_data[0];
				CFG_HYST_DIV:     cfg_q.hyst_div     <= cfg_data[DIV_W-1:0];
				CFG_QUIET_MS:     cfg_q.quiet_ms     <= cfg_data[QUIET_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/ccd_ladder.sv -----
// ccd_ladder: threshold ladder turning the average run-queue length into a
// requested core count, with hysteresis above the last request. Uses ccd_pkg.
module ccd_ladder (
	input  ccd_pkg::cfg_t                  cfg,
	input  logic [ccd_pkg::CORES_W-1:0]    last_request,
	input  logic [ccd_pkg::AVG_W-1:0]      avg,
	output logic [ccd_pkg::CORES_W-1:0]    req
);
	import ccd_pkg::*;

	logic [HYST_W-1:0]       hyst;
	logic [LADDER_STEPS-1:0] hit;

	assign hyst = hyst_amount(cfg.power_saving, cfg.hyst_div);

	// One independent compare per rung
	always_comb begin
		logic [THR_BASE_W-1:0] base;
		logic [CMP_W-1:0]      thr;
		for (int k = 0; k < LADDER_STEPS; k++) begin
			base = cfg.power_saving ? LADDER_SAVING : LADDER_NORMAL[k];
			if (last_request <= CORES_W'(k + 1))
				base = base + THR_BASE_W'(hyst);
			thr = CMP_W'(base);
			thr = cfg.power_saving ? (thr << (LOAD_FRAC_BITS - SHIFT_SAVING))
			                       : (thr << (LOAD_FRAC_BITS - SHIFT_NORMAL));
			hit[k] = CMP_W'(avg) <= thr;
		end
	end

	// First rung the load fits under sets the count; power saving uses only the first rung (one or two cores)
	always_comb begin
		if (cfg.power_saving) begin
			req = hit[0] ? CORES_W'(1) : CORES_W'(2);
		end else begin
			priority if (hit[0]) req = CORES_W'(1);
			else if (hit[1])     req = CORES_W'(2);
			else if (hit[2])     req = CORES_W'(3);
			else                 req = CORES_W'(4);
		end
	end

endmodule

// ----- rtl/ccd_core.sv -----
// ccd_core: governor state (dwell timer, previous time, last request) and the
// up/down decision for one sample. Instantiates ccd_ladder; uses ccd_pkg.
module ccd_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ccd_pkg::cfg_t                 cfg,
	input  logic                          fire,
	input  logic [ccd_pkg::NOW_W-1:0]     now_ms,
	input  logic [ccd_pkg::AVG_W-1:0]     avg_runnable_fx,
	input  logic [ccd_pkg::RUN_W-1:0]     runnable_count,
	input  logic [ccd_pkg::CORES_W-1:0]   cores_online,
	output ccd_pkg::decision_t            decision,
	output logic [ccd_pkg::CORES_W-1:0]   requested_cores
);
	import ccd_pkg::*;

	logic [CORES_W-1:0] last_request_q;
	logic [DWELL_W-1:0] dwell_q;
	logic [NOW_W-1:0]   prev_time_q;
	logic               first_q;

	logic               quiet;
	logic [CORES_W-1:0] online;
	logic [CORES_W-1:0] ladder_req;
	logic [NOW_W-1:0]   elapsed;
	logic [DWELL_W:0]   dwell_sum;
	logic [DWELL_W-1:0] dwell_acc;
	logic [DWELL_W-1:0] dwell_next;
	decision_t          dec;

	ccd_ladder u_ladder (
		.cfg          (cfg),
		.last_request (last_request_q),
		.avg          (avg_runnable_fx),
		.req          (ladder_req)
	);

	assign quiet  = now_ms <= NOW_W'(cfg.quiet_ms);
	assign online = (cores_online > CORES_MAX) ? CORES_MAX : cores_online;

	// Saturating dwell accumulation
	assign elapsed   = first_q ? '0 : now_ms - prev_time_q;
	assign dwell_sum = {1'b0, dwell_q} + {1'b0, elapsed};
	assign dwell_acc = dwell_sum[DWELL_W] ? '1 : dwell_sum[DWELL_W-1:0];

	// Table compares and decision
	always_comb begin
		dec        = DEC_IDLE;
		dwell_next = dwell_acc;
		if (online == '0) begin
			dwell_next = '0;
		end else if (online < cfg.max_cores && runnable_count >= up_count(online)) begin
			if (dwell_acc >= DWELL_W'(up_dwell(online)) && online < ladder_req)
				dec = DEC_UP;
		end else if (online > CORES_W'(1) && runnable_count <= down_count(online)) begin
			if (dwell_acc >= DWELL_W'(down_dwell(online)) && online > ladder_req)
				dec = DEC_DOWN;
		end else begin
			dwell_next = '0;
		end
		if (dec != DEC_IDLE)
			dwell_next = '0;
	end

	assign decision        = quiet ? DEC_IDLE : dec;
	assign requested_cores = quiet ? '0 : ladder_req;

	// State update; quiet samples leave it untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_request_q <= '0;
			dwell_q        <= '0;
			prev_time_q    <= '0;
			first_q        <= 1'b1;
		end else if (fire && !quiet) begin
			last_request_q <= ladder_req;
			dwell_q        <= dwell_next;
			prev_time_q    <= now_ms;
			first_q        <= 1'b0;
		end
	end

endmodule

// ----- rtl/core_count_hotplug_decision.sv -----
// core_count_hotplug_decision: top level of the run-queue core count governor.
// Instantiates ccd_cfg_regs and ccd_core; uses ccd_pkg.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one load sample per transfer. Each
//   sample gives exactly one result on m_tvalid/m_tready/m_tdata: the
//   decision (idle, one core down, one core up) and the requested core count.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the four registers
//   (max_cores, power_saving, hysteresis_divisor, startup_quiet_ms);
//   cfg_ready is always high. Write them only while no sample is in flight.
//   A sample is registered in the input register on acceptance, evaluated
//   against the governor state once the result register is free, and lands
//   in the result register, which drives m_tvalid and m_tdata.
//   Throughput: one sample per cycle while the receiver keeps m_tready high;
//   the dwell/ladder state is read and written as a sample moves into the
//   result register, so consecutive samples chain with no gap.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more sample; after that s_tready drops.
//   Reset (arst_n low) empties both registers, restores register defaults
//   and clears the governor state; the first sample afterwards adds no dwell.
module core_count_hotplug_decision (
	input  logic                             clk,
	input  logic                             arst_n,
	// now_ms[31:0], avg_runnable_fx[51:32], runnable_count[61:52],
	// cores_online[64:62], zero padding above
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ccd_pkg::IN_W-1:0]         s_tdata,
	// decision[1:0], requested_cores[4:2], zero padding above
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ccd_pkg::OUT_W-1:0]        m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ccd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ccd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ccd_pkg::*;

	localparam int AVG_LO = NOW_W;
	localparam int RUN_LO = AVG_LO + AVG_W;
	localparam int CORES_LO = RUN_LO + RUN_W;

	cfg_t cfg;

	logic               valid_s1;
	logic [NOW_W-1:0]   now_s1;
	logic [AVG_W-1:0]   avg_s1;
	logic [RUN_W-1:0]   run_s1;
	logic [CORES_W-1:0] online_s1;

	logic               out_valid_q;
	decision_t          out_dec_q;
	logic [CORES_W-1:0] out_req_q;

	logic               advance;
	decision_t          core_dec;
	logic [CORES_W-1:0] core_req;

	ccd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ccd_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.fire            (advance),
		.now_ms          (now_s1),
		.avg_runnable_fx (avg_s1),
		.runnable_count  (run_s1),
		.cores_online    (online_s1),
		.decision        (core_dec),
		.requested_cores (core_req)
	);

	// Handshake: stage 1 moves on when the result register is free
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			now_s1    <= s_tdata[AVG_LO-1:0];
			avg_s1    <= s_tdata[RUN_LO-1:AVG_LO];
			run_s1    <= s_tdata[CORES_LO-1:RUN_LO];
			online_s1 <= s_tdata[CORES_LO+CORES_W-1:CORES_LO];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_dec_q <= core_dec;
			out_req_q <= core_req;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_req_q, out_dec_q});

`ifndef ASSERT_OFF
	// A full stage 1 behind a stalled result blocks new input
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input accepted while both stages are stalled");

	// A waiting sample with an empty result register is delivered next cycle
	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |=> out_valid_q)
		else $error("stage 1 sample did not reach the result register");

	// A core change is only ever requested outside the quiet period
	a_move_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_dec_q != DEC_IDLE) |-> out_req_q != '0)
		else $error("core change decided with no requested cores");

	// An up decision always asks for more cores than are online
	a_up_needs_load: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && core_dec == DEC_UP) |-> core_req > online_s1)
		else $error("up decision without higher request");
`endif

endmodule
